FILE: rtl/eulr_pkg.sv
// Shared constants, types and the arctangent table for the Euler angle
// rotation matrix unit. No dependencies.
`default_nettype none

package eulr_pkg;

  // Field widths and defaults
  localparam int ANGLE_W            = 16;
  localparam int Q30_W              = 32;
  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int FRACTION_BITS_DEF  = 14;
  localparam int ATN_LEN            = 24;

  // Angle reduction, in units of 1/64 degree
  localparam int FULL_TURN          = 23040;
  localparam int QUARTER_TURN       = 5760;

  // pi in Q30 split as PI_HI * 2*QUARTER_TURN + PI_LO
  localparam int PI_HI              = 292817;
  localparam int PI_LO              = 7586;
  // 2^24 = 45 * RECIP_45 + 1
  localparam int DIV_45             = 45;
  localparam int RECIP_45           = 372827;

  localparam logic signed [Q30_W-1:0] GAIN_Q30 = 32'sd652032874;
  localparam logic signed [Q30_W-1:0] ONE_Q30  = 32'sd1073741824;

  // Pipeline depth outside the CORDIC steps
  localparam int LANE_FIXED_STAGES  = 6;
  localparam int MERGE_STAGES       = 4;
  localparam int ENTRY_CNT          = 9;

  // Cosine and sine of one angle, Q30
  typedef struct packed {
    logic signed [Q30_W-1:0] cos_v;
    logic signed [Q30_W-1:0] sin_v;
  } sc_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [Q30_W-1:0] atn_q30(input int idx);
    logic signed [Q30_W-1:0] v;
    case (idx)
      0:       v = 32'sd843314856;
      1:       v = 32'sd497837829;
      2:       v = 32'sd263043836;
      3:       v = 32'sd133525158;
      4:       v = 32'sd67021686;
      5:       v = 32'sd33543515;
      6:       v = 32'sd16775850;
      7:       v = 32'sd8388437;
      8:       v = 32'sd4194282;
      9:       v = 32'sd2097149;
      10:      v = 32'sd1048575;
      11:      v = 32'sd524287;
      12:      v = 32'sd262143;
      13:      v = 32'sd131071;
      14:      v = 32'sd65535;
      15:      v = 32'sd32767;
      16:      v = 32'sd16383;
      17:      v = 32'sd8191;
      18:      v = 32'sd4095;
      19:      v = 32'sd2047;
      20:      v = 32'sd1023;
      21:      v = 32'sd511;
      22:      v = 32'sd255;
      23:      v = 32'sd127;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // CORDIC step count, capped at the table length
  function automatic int cordic_len(input int steps);
    return (steps < ATN_LEN) ? steps : ATN_LEN;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/eulr_ifs.sv
// Valid/ready channel interfaces for the angle items and the matrix items.
// Depends on eulr_pkg.
`default_nettype none

interface eulr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [eulr_pkg::ANGLE_W-1:0]  angle_one;
  logic signed [eulr_pkg::ANGLE_W-1:0]  angle_two;
  logic signed [eulr_pkg::ANGLE_W-1:0]  angle_three;

  modport source(output valid, angle_one, angle_two, angle_three, input ready);
  modport sink(input valid, angle_one, angle_two, angle_three, output ready);
endinterface

interface eulr_out_if #(
  parameter int OUT_W = eulr_pkg::FRACTION_BITS_DEF + 2
);
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  r11;
  logic signed [OUT_W-1:0]  r12;
  logic signed [OUT_W-1:0]  r13;
  logic signed [OUT_W-1:0]  r21;
  logic signed [OUT_W-1:0]  r22;
  logic signed [OUT_W-1:0]  r23;
  logic signed [OUT_W-1:0]  r31;
  logic signed [OUT_W-1:0]  r32;
  logic signed [OUT_W-1:0]  r33;

  modport source(output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                 input ready);
  modport sink(input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
               output ready);
endinterface

`default_nettype wire

FILE: rtl/eulr_lane.sv
// One angle lane: modulo reduction, quadrant fold, radian conversion,
// pipelined CORDIC and quadrant unfold. Depends on eulr_pkg.
`default_nettype none

module eulr_lane #(
  parameter int CORDIC_STEPS = eulr_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                clk,
  input  wire logic [eulr_pkg::cordic_len(CORDIC_STEPS)
                     + eulr_pkg::LANE_FIXED_STAGES - 1:0] en,
  input  wire logic signed [eulr_pkg::ANGLE_W-1:0] angle,
  output eulr_pkg::sc_t                            sc
);
  import eulr_pkg::*;

  localparam int N = cordic_len(CORDIC_STEPS);
  localparam int L = N + LANE_FIXED_STAGES;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Stage registers
  logic [14:0]              r0_r;
  logic [12:0]              m1_r;
  logic [1:0]               q_r [N+4];
  logic [31:0]              am2_r;
  logic [25:0]              bx2_r;
  logic [31:0]              am3_r;
  logic [17:0]              y3_r;
  logic [12:0]              qe3_r;
  logic signed [Q30_W-1:0]  cx_r [N+1];
  logic signed [Q30_W-1:0]  cy_r [N+1];
  logic signed [Q30_W-1:0]  cz_r [N+1];
  sc_t                      sc_r;

  // Combinational helpers
  logic [17:0]              u;
  logic [14:0]              r_nxt;
  logic [12:0]              m_nxt;
  logic [1:0]               q_nxt;
  logic [36:0]              recip_prod;
  logic [17:0]              rem;
  logic                     corr;
  logic signed [Q30_W-1:0]  cos_raw;
  logic signed [Q30_W-1:0]  sin_raw;

  function automatic logic signed [Q30_W-1:0] clamp1(input logic signed [Q30_W-1:0] v);
    logic signed [Q30_W-1:0] o;
    if (v > ONE_Q30) begin
      o = ONE_Q30;
    end else if (v < -ONE_Q30) begin
      o = -ONE_Q30;
    end else begin
      o = v;
    end
    return o;
  endfunction

  // Reduce the angle modulo a full turn
  always_comb begin
    u = {{2{angle[ANGLE_W-1]}}, angle} + 18'(2 * FULL_TURN);
    if (u >= 18'(3 * FULL_TURN)) begin
      r_nxt = 15'(u - 18'(3 * FULL_TURN));
    end else if (u >= 18'(2 * FULL_TURN)) begin
      r_nxt = 15'(u - 18'(2 * FULL_TURN));
    end else if (u >= 18'(FULL_TURN)) begin
      r_nxt = 15'(u - 18'(FULL_TURN));
    end else begin
      r_nxt = u[14:0];
    end
  end

  // Split into quadrant and remainder
  always_comb begin
    if (r0_r >= 15'(3 * QUARTER_TURN)) begin
      q_nxt = QUAD_3;
      m_nxt = 13'(r0_r - 15'(3 * QUARTER_TURN));
    end else if (r0_r >= 15'(2 * QUARTER_TURN)) begin
      q_nxt = QUAD_2;
      m_nxt = 13'(r0_r - 15'(2 * QUARTER_TURN));
    end else if (r0_r >= 15'(QUARTER_TURN)) begin
      q_nxt = QUAD_1;
      m_nxt = 13'(r0_r - 15'(QUARTER_TURN));
    end else begin
      q_nxt = QUAD_0;
      m_nxt = r0_r[12:0];
    end
  end

  // Divide by 45 through the reciprocal, then fix the estimate by one
  always_comb begin
    recip_prod = 37'(bx2_r[25:8]) * 37'(RECIP_45);
    rem        = y3_r - 18'(18'(qe3_r) * 18'(DIV_45));
    corr       = (rem >= 18'(DIV_45));
  end

  // Undo the quadrant fold
  always_comb begin
    case (q_r[N+3])
      QUAD_1: begin
        cos_raw = -cy_r[N];
        sin_raw = cx_r[N];
      end
      QUAD_2: begin
        cos_raw = -cx_r[N];
        sin_raw = -cy_r[N];
      end
      QUAD_3: begin
        cos_raw = cy_r[N];
        sin_raw = -cx_r[N];
      end
      default: begin
        cos_raw = cx_r[N];
        sin_raw = cy_r[N];
      end
    endcase
  end

  // Advance the reduction and conversion stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      r0_r <= r_nxt;
    end
    if (en[1]) begin
      m1_r <= m_nxt;
    end
    if (en[2]) begin
      am2_r <= 32'(32'(m1_r) * 32'(PI_HI));
      bx2_r <= 26'(26'(m1_r) * 26'(PI_LO) + 26'(QUARTER_TURN));
    end
    if (en[3]) begin
      am3_r <= am2_r;
      y3_r  <= bx2_r[25:8];
      qe3_r <= recip_prod[36:24];
    end
  end

  // Carry the quadrant alongside the datapath
  always_ff @(posedge clk) begin
    if (en[1]) begin
      q_r[0] <= q_nxt;
    end
    for (int j = 1; j < N + 4; j++) begin
      if (en[1+j]) begin
        q_r[j] <= q_r[j-1];
      end
    end
  end

  // Load the CORDIC start vector, then rotate one step per stage
  always_ff @(posedge clk) begin
    if (en[4]) begin
      cx_r[0] <= GAIN_Q30;
      cy_r[0] <= '0;
      cz_r[0] <= $signed(am3_r + 32'(qe3_r) + 32'(corr));
    end
    for (int i = 0; i < N; i++) begin
      if (en[5+i]) begin
        if (!cz_r[i][Q30_W-1]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - atn_q30(i);
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + atn_q30(i);
        end
      end
    end
  end

  // Clamp and hold the lane result
  always_ff @(posedge clk) begin
    if (en[L-1]) begin
      sc_r.cos_v <= clamp1(cos_raw);
      sc_r.sin_v <= clamp1(sin_raw);
    end
  end

  assign sc = sc_r;

endmodule

`default_nettype wire

FILE: rtl/eulr_merge.sv
// Merge stage: forms the nine rotation entries from the three lanes'
// cosines and sines, then rounds and saturates them. Depends on eulr_pkg.
`default_nettype none

module eulr_merge #(
  parameter int FRACTION_BITS = eulr_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic [eulr_pkg::MERGE_STAGES-1:0]           en,
  input  wire eulr_pkg::sc_t                               sc1,
  input  wire eulr_pkg::sc_t                               sc2,
  input  wire eulr_pkg::sc_t                               sc3,
  output logic [eulr_pkg::ENTRY_CNT-1:0][FRACTION_BITS+1:0] entry
);
  import eulr_pkg::*;

  localparam int OUT_W = FRACTION_BITS + 2;
  localparam int SH    = 30 - FRACTION_BITS;
  localparam logic signed [33:0] ROUND_V = (34'sd1 <<< SH) >>> 1;
  localparam logic signed [33:0] ONE_V   = 34'sd1 <<< FRACTION_BITS;

  typedef logic signed [Q30_W-1:0] q30_t;
  typedef logic signed [Q30_W:0]   sum_t;

  // First products
  q30_t c1c3_r, c2s1_r, c3s1_r, c1c2_r, s2s3_r, c1s3_r;
  q30_t c2c3_r, c3s2_r, s1s2_r, c1s2_r, s1s3_r;
  q30_t s1_1_r, s3_1_r, c3_1_r, c2_1_r;
  // Second products and carried terms
  q30_t t11_r, t12_r, t21_r, t22_r;
  q30_t c1c3_2_r, c3s1_2_r, s2s3_2_r, c1s3_2_r, s1s3_2_r;
  q30_t c3s2_2_r, s1s2_2_r, c1s2_2_r, c2_2_r;
  // Q30 entries before rounding
  sum_t e_r [ENTRY_CNT];
  logic [ENTRY_CNT-1:0][OUT_W-1:0] entry_r;

  // Q30 product rounded half up
  function automatic q30_t q30_mul(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
    return p[61:30];
  endfunction

  function automatic sum_t sx(input q30_t a);
    return {a[Q30_W-1], a};
  endfunction

  // Round to the output fraction, saturate to plus or minus one
  function automatic logic [OUT_W-1:0] finish(input sum_t v);
    logic signed [33:0] s;
    s = {v[Q30_W], v} + ROUND_V;
    s = s >>> SH;
    if (s > ONE_V) begin
      s = ONE_V;
    end else if (s < -ONE_V) begin
      s = -ONE_V;
    end
    return s[OUT_W-1:0];
  endfunction

  // Pairwise products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      c1c3_r <= q30_mul(sc1.cos_v, sc3.cos_v);
      c2s1_r <= q30_mul(sc2.cos_v, sc1.sin_v);
      c3s1_r <= q30_mul(sc3.cos_v, sc1.sin_v);
      c1c2_r <= q30_mul(sc1.cos_v, sc2.cos_v);
      s2s3_r <= q30_mul(sc2.sin_v, sc3.sin_v);
      c1s3_r <= q30_mul(sc1.cos_v, sc3.sin_v);
      c2c3_r <= q30_mul(sc2.cos_v, sc3.cos_v);
      c3s2_r <= q30_mul(sc3.cos_v, sc2.sin_v);
      s1s2_r <= q30_mul(sc1.sin_v, sc2.sin_v);
      c1s2_r <= q30_mul(sc1.cos_v, sc2.sin_v);
      s1s3_r <= q30_mul(sc1.sin_v, sc3.sin_v);
      s1_1_r <= sc1.sin_v;
      s3_1_r <= sc3.sin_v;
      c3_1_r <= sc3.cos_v;
      c2_1_r <= sc2.cos_v;
    end
  end

  // Third factors
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t11_r    <= q30_mul(c2s1_r, s3_1_r);
      t12_r    <= q30_mul(c1c2_r, s3_1_r);
      t21_r    <= q30_mul(c2c3_r, s1_1_r);
      t22_r    <= q30_mul(c1c2_r, c3_1_r);
      c1c3_2_r <= c1c3_r;
      c3s1_2_r <= c3s1_r;
      s2s3_2_r <= s2s3_r;
      c1s3_2_r <= c1s3_r;
      s1s3_2_r <= s1s3_r;
      c3s2_2_r <= c3s2_r;
      s1s2_2_r <= s1s2_r;
      c1s2_2_r <= c1s2_r;
      c2_2_r   <= c2_1_r;
    end
  end

  // Combine terms into entries
  always_ff @(posedge clk) begin
    if (en[2]) begin
      e_r[0] <= sx(c1c3_2_r) - sx(t11_r);
      e_r[1] <= sx(c3s1_2_r) + sx(t12_r);
      e_r[2] <= sx(s2s3_2_r);
      e_r[3] <= -sx(c1s3_2_r) - sx(t21_r);
      e_r[4] <= sx(t22_r) - sx(s1s3_2_r);
      e_r[5] <= sx(c3s2_2_r);
      e_r[6] <= sx(s1s2_2_r);
      e_r[7] <= -sx(c1s2_2_r);
      e_r[8] <= sx(c2_2_r);
    end
  end

  // Round and saturate into the output register
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < ENTRY_CNT; k++) begin
        entry_r[k] <= finish(e_r[k]);
      end
    end
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

FILE: rtl/euler_angle_rotation_matrix_unit.sv
// Bunge Z-X-Z Euler angle rotation matrix unit.
// Throughput: one item per cycle; stages advance independently, so bubbles
// close up and a stalled output holds only the run of full stages behind it.
// Reset clears the stage valid bits only; the datapath is not reset.
// Depends on eulr_pkg, eulr_ifs, eulr_lane and eulr_merge.
`default_nettype none

module euler_angle_rotation_matrix_unit #(
  parameter int CORDIC_STEPS  = eulr_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = eulr_pkg::FRACTION_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  eulr_in_if.sink     in_ch,
  eulr_out_if.source  out_ch
);
  import eulr_pkg::*;

  localparam int LANE_D = cordic_len(CORDIC_STEPS) + LANE_FIXED_STAGES;
  localparam int DEPTH  = LANE_D + MERGE_STAGES;
  localparam int OUT_W  = FRACTION_BITS + 2;

  logic [DEPTH-1:0]                v_r;
  logic [DEPTH-1:0]                v_nxt;
  logic [DEPTH-1:0]                en;
  sc_t                             sc1, sc2, sc3;
  logic [ENTRY_CNT-1:0][OUT_W-1:0] entry;

  // A stage loads when it or any stage after it is empty, or the output drains
  for (genvar k = 0; k < DEPTH; k++) begin : g_en
    assign en[k] = out_ch.ready || !(&v_r[DEPTH-1:k]);
  end

  // Advance the valid bits with their stages
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_ch.valid : v_r[(k == 0) ? 0 : k - 1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // One lane per angle
  eulr_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane1 (
    .clk   (clk),
    .en    (en[LANE_D-1:0]),
    .angle (in_ch.angle_one),
    .sc    (sc1)
  );

  eulr_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane2 (
    .clk   (clk),
    .en    (en[LANE_D-1:0]),
    .angle (in_ch.angle_two),
    .sc    (sc2)
  );

  eulr_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane3 (
    .clk   (clk),
    .en    (en[LANE_D-1:0]),
    .angle (in_ch.angle_three),
    .sc    (sc3)
  );

  // Combine the lanes into the matrix
  eulr_merge #(.FRACTION_BITS(FRACTION_BITS)) u_merge (
    .clk   (clk),
    .en    (en[DEPTH-1:LANE_D]),
    .sc1   (sc1),
    .sc2   (sc2),
    .sc3   (sc3),
    .entry (entry)
  );

  assign in_ch.ready  = en[0];
  assign out_ch.valid = v_r[DEPTH-1];
  assign out_ch.r11   = entry[0];
  assign out_ch.r12   = entry[1];
  assign out_ch.r13   = entry[2];
  assign out_ch.r21   = entry[3];
  assign out_ch.r22   = entry[4];
  assign out_ch.r23   = entry[5];
  assign out_ch.r31   = entry[6];
  assign out_ch.r32   = entry[7];
  assign out_ch.r33   = entry[8];

endmodule

`default_nettype wire
